// ----- hw/rtl/stis_pkg.sv -----
// ============================================================================
// stis_pkg
// Shared types and constants for the sorted table with insert, delete, search.
// ============================================================================
package stis_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int VAL_W       = 32;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_FOUND     = 3'd5;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic signed [VAL_W-1:0] key;
        logic [CNT_W-1:0]        fill;
        logic                    ins;
        logic                    del;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/sorted_table_insert_delete_search.sv -----
// ============================================================================
// sorted_table_insert_delete_search
// Sorted table of signed 32-bit values kept in a row of compare-and-shift cells.
// ============================================================================
//
//  Channel   Signals                          Direction  Handshake
//  -------   ------------------------------   ---------  ---------------------
//  command   start, operation, value, busy    in         start && !busy
//  result    done, status, position,          out        done, one cycle,
//            entry_count                                 cannot be held off
//
// The edge that accepts an item latches the operation and value, and the
// next edge updates every cell at once and loads the result, which shows on
// the result ports with done high for the following cycle. busy is high
// between those edges, so no new item is taken while one is in flight; another
// can be accepted at the same edge that ends the cycle of the previous result.
// Reset empties the table by clearing the entry count; the cells themselves
// hold no reset and are never read beyond the count.
//
module sorted_table_insert_delete_search
    import stis_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [1:0]              operation,
    input  logic signed [VAL_W-1:0] value,
    output logic                    busy,
    output logic                    done,
    output logic [2:0]              status,
    output logic [CNT_W-1:0]        position,
    output logic [CNT_W-1:0]        entry_count
);

    // Latched command.
    logic                    pend_reg;
    logic [1:0]              op_reg;
    logic signed [VAL_W-1:0] val_reg;

    // Table count and result registers.
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             done_reg;
    logic [2:0]       status_reg;
    logic [2:0]       status_next;
    logic [CNT_W-1:0] position_reg;
    logic [CNT_W-1:0] position_next;

    // Cell row wiring.
    cell_ctrl_t              ctrl;
    logic signed [VAL_W-1:0] entries [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  lt_vec;
    logic [TABLE_DEPTH-1:0]  hit_vec;
    logic                    found;
    logic [IDX_W-1:0]        hit_idx;

    logic accept;

    assign accept = start && !pend_reg;

    // The command is held in one register stage; the cells act on it in the
    // cycle after acceptance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            val_reg <= value;
        end
    end

    // A match can only sit at the insertion point, since the table is sorted
    // and that point is the first entry not below the key.
    assign found = |hit_vec;

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (hit_vec[i])
                hit_idx = hit_idx | IDX_W'(i);
        end
    end

    assign ctrl.key  = val_reg;
    assign ctrl.fill = fill_reg;
    assign ctrl.ins  = pend_reg && (op_reg == OP_INSERT) && (fill_reg != FULL_COUNT);
    assign ctrl.del  = pend_reg && (op_reg == OP_DELETE) && found;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            logic                    lt_left;
            logic signed [VAL_W-1:0] entry_left;
            logic signed [VAL_W-1:0] entry_right;

            if (g == 0)
            begin : g_first
                assign lt_left    = 1'b1;
                assign entry_left = '0;
            end
            else
            begin : g_inner
                assign lt_left    = lt_vec[g-1];
                assign entry_left = entries[g-1];
            end

            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign entry_right = '0;
            end
            else
            begin : g_body
                assign entry_right = entries[g+1];
            end

            stis_cell u_cell (
                .clk         (clk),
                .idx         (IDX_W'(g)),
                .ctrl        (ctrl),
                .lt_left     (lt_left),
                .entry_left  (entry_left),
                .entry_right (entry_right),
                .entry       (entries[g]),
                .lt          (lt_vec[g]),
                .hit         (hit_vec[g])
            );
        end
    endgenerate

    // Result decode for the operation in flight.
    always_comb
    begin
        status_next   = ST_NOT_FOUND;
        position_next = '0;
        fill_next     = fill_reg;
        case (op_reg)
            OP_INSERT:
            begin
                if (fill_reg == FULL_COUNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    fill_next   = fill_reg + 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (fill_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (found)
                begin
                    status_next = ST_DELETED;
                    fill_next   = fill_reg - 1'b1;
                end
            end
            OP_SEARCH:
            begin
                if (found)
                begin
                    status_next   = ST_FOUND;
                    position_next = {1'b0, hit_idx} + 1'b1;
                end
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pend_reg;
            if (pend_reg)
                fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
        end
    end

    assign busy        = pend_reg;
    assign done        = done_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_count = fill_reg;

endmodule

// ----- hw/rtl/stis_cell.sv -----
// ============================================================================
// stis_cell
// One slot of the sorted row: compares its entry with the key and shifts.
// ============================================================================
module stis_cell
    import stis_pkg::*;
(
    input  logic                    clk,
    input  logic [IDX_W-1:0]        idx,
    input  cell_ctrl_t              ctrl,
    input  logic                    lt_left,
    input  logic signed [VAL_W-1:0] entry_left,
    input  logic signed [VAL_W-1:0] entry_right,
    output logic signed [VAL_W-1:0] entry,
    output logic                    lt,
    output logic                    hit
);

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;
    logic                    valid;
    logic                    at_k;
    logic                    after_k;

    assign valid = {1'b0, idx} < ctrl.fill;
    assign lt    = valid && (entry_reg < ctrl.key);
    // The entries below the key form a prefix, so the insertion point is the
    // first cell that is not below the key while its left neighbor is.
    assign at_k    = lt_left && !lt;
    assign after_k = !lt_left;
    assign hit     = at_k && valid && (entry_reg == ctrl.key);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (at_k)
                entry_next = ctrl.key;
            else if (after_k)
                entry_next = entry_left;
        end
        else if (ctrl.del && !lt)
        begin
            entry_next = entry_right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- hw/rtl/stis_checker.sv -----
// ============================================================================
// stis_checker
// Port-level checks for the sorted table, bound to the top level.
// ============================================================================
module stis_checker
    import stis_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    done,
    input  logic [2:0]              status,
    input  logic [CNT_W-1:0]        position,
    input  logic [CNT_W-1:0]        entry_count
);

    // An accepted item always yields its result, strobed by done once the latched command has been acted on.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted item produced no result");

    // A search hit reports a position inside the table, anything else reports 0.
    a_position: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == ST_FOUND) ? (position != '0 && position <= entry_count)
                                       : (position == '0)))
        else $error("position does not agree with status");

    // A successful insert whose result does not come straight after another result leaves at least one entry.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done, 2) == 1'b0 && $past(done) == 1'b0 && status == ST_INSERTED)
        |-> (entry_count != '0))
        else $error("insert left the table empty");

    // The count never exceeds the table depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= FULL_COUNT)
        else $error("entry count beyond table depth");

    // Full is only reported when the table is at capacity.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (entry_count == FULL_COUNT))
        else $error("full reported below capacity");

endmodule

bind sorted_table_insert_delete_search stis_checker u_stis_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
);

// ----- verif/sorted_table_insert_delete_search_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sorted_table_insert_delete_search_test
// Self-checking test of the sorted table. Operations go through the
// start/busy command port. A shadow copy of the table predicts each result,
// and every strobed result is compared field by field with the oldest
// prediction.
// ============================================================================
module sorted_table_insert_delete_search_test
    import stis_pkg::*;
();

    // Operation code 3 is unused by the block, but it still answers it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // The slowest correct run is about 1700 items plus the gaps after some
    // of them, so this limit leaves a wide margin.
    localparam int CYCLE_LIMIT = 250000;

    typedef struct {
        logic [1:0]              op;
        logic signed [VAL_W-1:0] operand;
        logic [2:0]              status;
        logic [CNT_W-1:0]        position;
        logic [CNT_W-1:0]        count;
    } table_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic [1:0]              operation;
    logic signed [VAL_W-1:0] value;
    logic                    busy;
    logic                    done;
    logic [2:0]              status;
    logic [CNT_W-1:0]        position;
    logic [CNT_W-1:0]        entry_count;

    // Shadow of the table contents. Only the first held_count slots matter.
    logic signed [VAL_W-1:0] held_values [TABLE_DEPTH];
    int                      held_count;

    // Predicted results in the order their items were accepted.
    table_result_t pending_results [$];

    int fail_count;
    int items_sent;
    int results_checked;
    int cycle_count;
    int status_tally [6];

    // Odds of a gap after an item: 1 in gap_odds, or never when it is zero.
    int gap_odds;

    sorted_table_insert_delete_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .operation   (operation),
        .value       (value),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .position    (position),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Apply one operation to the shadow table and return the result that
    // the block should give for it.
    function automatic table_result_t apply_table_op(logic [1:0] op,
                                                     logic signed [VAL_W-1:0] v);
        table_result_t r;
        int            k;
        int            i;
        r.op       = op;
        r.operand  = v;
        r.status   = ST_NOT_FOUND;
        r.position = '0;
        // First equal entry, or held_count when there is none.
        k = 0;
        while (k < held_count && held_values[k] != v)
            k++;
        case (op)
            OP_INSERT:
            begin
                if (held_count >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // The new value goes ahead of any equal entries.
                    k = 0;
                    while (k < held_count && held_values[k] < v)
                        k++;
                    for (i = held_count; i > k; i--)
                        held_values[i] = held_values[i-1];
                    held_values[k] = v;
                    held_count++;
                    r.status = ST_INSERTED;
                end
            end
            OP_DELETE:
            begin
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else if (k < held_count)
                begin
                    for (i = k; i + 1 < held_count; i++)
                        held_values[i] = held_values[i+1];
                    held_count--;
                    r.status = ST_DELETED;
                end
            end
            OP_SEARCH:
            begin
                if (k < held_count)
                begin
                    r.status   = ST_FOUND;
                    r.position = CNT_W'(k + 1);
                end
            end
            default:
                ;
        endcase
        r.count = CNT_W'(held_count);
        return r;
    endfunction

    // Operand mix: mostly a narrow band around zero so that values repeat,
    // often a value that is held right now so that searches and deletes
    // hit, and sometimes the extremes or a fully random word.
    function automatic logic signed [VAL_W-1:0] pick_operand();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $signed(VAL_W'($urandom_range(0, 16))) - 8;
        else if (pick < 65 && held_count > 0)
            return held_values[$urandom_range(0, held_count - 1)];
        else if (pick < 75)
        begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $signed($urandom());
    endfunction

    // Present one item from a falling edge and hold it until a rising edge
    // sees busy low. The shadow table is updated at that same edge. start
    // stays high afterwards unless a gap follows, so back-to-back items
    // never lower and raise it within one time step.
    task automatic send_op(logic [1:0] op, logic signed [VAL_W-1:0] v);
        @(negedge clk);
        start     <= 1'b1;
        operation <= op;
        value     <= v;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_table_op(op, v));
        items_sent++;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
            pause_cycles($urandom_range(1, 19));
    endtask

    // Keep start low for a gap whose length is given by n. The next send_op
    // raises it again at the falling edge after the gap.
    task automatic pause_cycles(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Lower start before the block can take the last item a second time,
    // then wait until every predicted result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Empty-table answers, the value extremes, duplicates, first-match
    // positions, absent values and the unused operation code.
    task automatic test_directed_corners();
        gap_odds = 0;
        send_op(OP_SEARCH, 0);
        send_op(OP_DELETE, 5);
        send_op(OP_UNUSED, 7);
        send_op(OP_INSERT, VAL_MAX);
        send_op(OP_INSERT, VAL_MIN);
        send_op(OP_INSERT, 0);
        send_op(OP_INSERT, -1);
        send_op(OP_INSERT, 1);
        send_op(OP_INSERT, 0);
        send_op(OP_INSERT, VAL_MIN);
        send_op(OP_SEARCH, VAL_MIN);
        send_op(OP_SEARCH, 0);
        send_op(OP_SEARCH, VAL_MAX);
        send_op(OP_SEARCH, 42);
        send_op(OP_DELETE, 42);
        send_op(OP_DELETE, 0);
        send_op(OP_SEARCH, 0);
        send_op(OP_UNUSED, 0);
        send_op(OP_DELETE, VAL_MAX);
        send_op(OP_DELETE, VAL_MIN);
        send_op(OP_DELETE, VAL_MIN);
        send_op(OP_SEARCH, VAL_MIN);
        send_op(OP_INSERT, 32'sh5555_5555);
        send_op(OP_INSERT, 32'shAAAA_AAAA);
        send_op(OP_SEARCH, 32'shAAAA_AAAA);
    endtask

    // Random operations in blocks of 50. Each block leans toward inserts or
    // toward deletes, so the table swings between nearly empty and full,
    // and each block has gaps or runs without any.
    task automatic test_random_mix(int blocks);
        int          b;
        int          n;
        int          ins_weight;
        int          pick;
        logic [1:0]  op;
        for (b = 0; b < blocks; b++)
        begin
            ins_weight = $urandom_range(20, 60);
            gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            for (n = 0; n < 50; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < ins_weight)
                    op = OP_INSERT;
                else if (pick < 70)
                    op = OP_DELETE;
                else if (pick < 95)
                    op = OP_SEARCH;
                else
                    op = OP_UNUSED;
                send_op(op, pick_operand());
            end
        end
    endtask

    // Fill the table to capacity and insert into the full table, search it
    // while full, then drain it one held value at a time and delete from
    // the empty table.
    task automatic test_fill_and_drain(int rounds);
        int r;
        int n;
        for (r = 0; r < rounds; r++)
        begin
            gap_odds = (r % 2 == 0) ? 4 : 0;
            while (held_count < TABLE_DEPTH)
                send_op(OP_INSERT, pick_operand());
            for (n = 0; n < 4; n++)
                send_op(OP_INSERT, pick_operand());
            send_op(OP_SEARCH, held_values[TABLE_DEPTH - 1]);
            send_op(OP_SEARCH, held_values[0]);
            send_op(OP_SEARCH, pick_operand());
            while (held_count > 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_op(OP_DELETE, $signed($urandom()));
                else
                    send_op(OP_DELETE, held_values[$urandom_range(0, held_count - 1)]);
            end
            for (n = 0; n < 3; n++)
                send_op(OP_DELETE, pick_operand());
            send_op(OP_SEARCH, pick_operand());
        end
    endtask

    // The last part of the run: items offered on every cycle, no gaps, and taken whenever busy is low.
    task automatic test_back_to_back(int count);
        int n;
        gap_odds = 0;
        for (n = 0; n < count; n++)
            send_op(2'($urandom_range(0, 3)), pick_operand());
    endtask

    // Each strobed result is checked against the oldest prediction. done
    // and the result fields are sampled at the edge that ends their cycle.
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing pending: status %0d position %0d count %0d",
                         $time, status, position, entry_count);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (status < 6)
                    status_tally[status]++;
                if (status !== want.status)
                begin
                    $display("%0t: op %0d value %0d: status expected %0d actual %0d",
                             $time, want.op, want.operand, want.status, status);
                    fail_count++;
                end
                if (position !== want.position)
                begin
                    $display("%0t: op %0d value %0d: position expected %0d actual %0d",
                             $time, want.op, want.operand, want.position, position);
                    fail_count++;
                end
                if (entry_count !== want.count)
                begin
                    $display("%0t: op %0d value %0d: entry_count expected %0d actual %0d",
                             $time, want.op, want.operand, want.count, entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles with %0d results pending",
                     $time, CYCLE_LIMIT, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = OP_INSERT;
        value      = '0;
        held_count = 0;
        gap_odds   = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed_corners();
        // Hold off until the directed results are all in, so that the random
        // part starts from a quiet block.
        wait_for_results();
        test_random_mix(16);
        test_fill_and_drain(3);
        test_back_to_back(420);

        @(negedge clk);
        start <= 1'b0;
        wait_for_results();
        // Wait on past the last result so that any stray strobe would show.
        repeat (4) @(posedge clk);

        $display("Sent %0d items and checked %0d results, including full and empty tables.",
                 items_sent, results_checked);
        $display("Statuses seen: inserted %0d, full %0d, deleted %0d, not found %0d, empty %0d, found %0d",
                 status_tally[0], status_tally[1], status_tally[2],
                 status_tally[3], status_tally[4], status_tally[5]);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
